// File: rtl/otr_pkg.sv
// shared types and constants of the overwriting trace ring
// no dependencies; imported by every rtl module of the block
`default_nettype none

package otr_pkg;

	// ring depth must be a power of two: slots are the low bits of the counts
	localparam int RING_DEPTH  = 1024;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int BURST_LIMIT = 64;
	localparam int CNT_W       = 7;

	localparam logic [63:0]      DEPTH64   = 64'(RING_DEPTH);
	localparam logic [63:0]      ALL_ONES  = '1;
	localparam logic [CNT_W-1:0] BURST_MAX = CNT_W'(BURST_LIMIT);

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	typedef struct packed {
		logic [7:0]  cpu;
		logic [31:0] code;
		logic [63:0] ip;
		logic [63:0] detail_a;
		logic [63:0] detail_b;
		logic [63:0] reg_a;
		logic [63:0] reg_c;
		logic [63:0] stamp;
	} entry_t;

	typedef struct packed {
		logic rec;
		logic load;
		logic resolve;
		logic overrun;
		logic check;
		logic issue;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic zero_lim;
		logic empty;
		logic last_one;
		logic adv;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/otr_ctrl.sv
// controller state machine of the trace ring
// depends on otr_pkg; drives otr_datapath through cmd_t, reads sts_t
`default_nettype none

module otr_ctrl import otr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic command,
	input  sts_t sts,
	output logic in_stall,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_RESOLVE = 6'b000010,
		ST_OVERRUN = 6'b000100,
		ST_CHECK   = 6'b001000,
		ST_EMIT    = 6'b010000,
		ST_FINAL   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.rec  = accept && (command == CMD_RECORD);
				cmd.load = accept && (command == CMD_DRAIN);
				if (accept && (command == CMD_DRAIN)) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				cmd.resolve = !sts.zero_lim;
				state_d     = sts.zero_lim ? ST_FINAL : ST_OVERRUN;
			end
			ST_OVERRUN: begin
				cmd.overrun = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.empty ? ST_FINAL : ST_EMIT;
			end
			ST_EMIT: begin
				cmd.issue = sts.adv;
				if (sts.adv && sts.last_one) begin
					state_d = ST_IDLE;
				end
			end
			ST_FINAL: begin
				cmd.fin = sts.adv;
				if (sts.adv) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/otr_datapath.sv
// datapath of the trace ring: head count, cursor arithmetic, entry memory
// and the output register; depends on otr_pkg, steered by otr_ctrl
`default_nettype none

module otr_datapath import otr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  entry_t      wr_entry,
	input  logic [63:0] read_cursor,
	input  logic [6:0]  max_count,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        has_entry,
	output logic [7:0]  out_cpu,
	output logic [31:0] out_code,
	output logic [63:0] out_ip,
	output logic [63:0] out_detail_a,
	output logic [63:0] out_detail_b,
	output logic [63:0] out_reg_a,
	output logic [63:0] out_reg_c,
	output logic [63:0] out_stamp,
	output logic        last,
	output logic [63:0] next_cursor,
	output logic [63:0] lost_count
);

	entry_t ring_mem [RING_DEPTH];

	logic [63:0]      head_q;
	logic [63:0]      pos_q;
	logic [63:0]      hmd_q;
	logic [63:0]      lost_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] cnt_q;

	entry_t           rd_s1;
	logic             valid_s1;
	logic             has_s1;
	logic             last_s1;
	logic [63:0]      cur_s1;
	logic [63:0]      lost_s1;

	logic [63:0]      res_pos;
	logic             ovr;
	logic [63:0]      avail;
	logic [CNT_W-1:0] n_calc;

	// cursor resolution, overrun test and burst size
	always_comb begin
		if (pos_q == '0) begin
			res_pos = (head_q > DEPTH64) ? head_q - DEPTH64 : '0;
		end else if (pos_q == ALL_ONES) begin
			res_pos = head_q;
		end else begin
			res_pos = pos_q;
		end
		ovr    = head_q > (pos_q + DEPTH64);
		avail  = head_q - pos_q;
		n_calc = (avail < 64'(lim_q)) ? avail[CNT_W-1:0] : lim_q;
	end

	assign sts.zero_lim = (lim_q == '0);
	assign sts.empty    = (head_q == '0) || (pos_q >= head_q);
	assign sts.last_one = (cnt_q == CNT_W'(1));
	assign sts.adv      = !valid_s1 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (cmd.rec) begin
			head_q <= head_q + 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec) begin
			ring_mem[head_q[RING_AW-1:0]] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_s1 <= ring_mem[pos_q[RING_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q  <= read_cursor;
			lost_q <= '0;
			lim_q  <= (max_count > BURST_MAX) ? BURST_MAX : max_count;
		end
		if (cmd.resolve) begin
			pos_q <= res_pos;
			hmd_q <= head_q - DEPTH64;
		end
		if (cmd.overrun && ovr) begin
			lost_q <= hmd_q - pos_q;
			pos_q  <= hmd_q;
		end
		if (cmd.check) begin
			cnt_q <= n_calc;
		end
		if (cmd.issue) begin
			pos_q <= pos_q + 64'd1;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.issue || cmd.fin) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			has_s1  <= 1'b1;
			last_s1 <= sts.last_one;
			cur_s1  <= pos_q + 64'd1;
			lost_s1 <= lost_q;
		end else if (cmd.fin) begin
			has_s1  <= 1'b0;
			last_s1 <= 1'b1;
			cur_s1  <= pos_q;
			lost_s1 <= lost_q;
		end
	end

	assign out_valid    = valid_s1;
	assign has_entry    = has_s1;
	assign out_cpu      = has_s1 ? rd_s1.cpu : '0;
	assign out_code     = has_s1 ? rd_s1.code : '0;
	assign out_ip       = has_s1 ? rd_s1.ip : '0;
	assign out_detail_a = has_s1 ? rd_s1.detail_a : '0;
	assign out_detail_b = has_s1 ? rd_s1.detail_b : '0;
	assign out_reg_a    = has_s1 ? rd_s1.reg_a : '0;
	assign out_reg_c    = has_s1 ? rd_s1.reg_c : '0;
	assign out_stamp    = has_s1 ? rd_s1.stamp : '0;
	assign last         = last_s1;
	assign next_cursor  = last_s1 ? cur_s1 : '0;
	assign lost_count   = last_s1 ? lost_s1 : '0;

endmodule

`default_nettype wire

// File: rtl/overwriting_trace_ring_unit.sv
// top level of the overwriting trace ring
// depends on otr_pkg, otr_ctrl and otr_datapath
`default_nettype none

// A record request does not block the input: the next request can follow in
// the next cycle. A drain holds in_stall through 64-bit cursor resolution,
// overrun check and burst-size check, then returns one entry per cycle out of
// the single-port entry memory, less whenever out_stall holds the output
// register; with max_count 0 it skips resolution and checks, and with nothing
// retained past the cursor it skips the entries, in an empty final result.
// The ring keeps the last 1024 records; the entry memory has no reset and
// needs no clearing pass.
module overwriting_trace_ring_unit import otr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  cpu_id,
	input  logic [31:0] exit_code,
	input  logic [63:0] instr_ptr,
	input  logic [63:0] detail_a,
	input  logic [63:0] detail_b,
	input  logic [63:0] reg_a_value,
	input  logic [63:0] reg_c_value,
	input  logic [63:0] stamp,
	input  logic [63:0] read_cursor,
	input  logic [6:0]  max_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        has_entry,
	output logic [7:0]  out_cpu,
	output logic [31:0] out_code,
	output logic [63:0] out_ip,
	output logic [63:0] out_detail_a,
	output logic [63:0] out_detail_b,
	output logic [63:0] out_reg_a,
	output logic [63:0] out_reg_c,
	output logic [63:0] out_stamp,
	output logic        last,
	output logic [63:0] next_cursor,
	output logic [63:0] lost_count
);

	cmd_t   cmd;
	sts_t   sts;
	entry_t wr_entry;

	assign wr_entry.cpu      = cpu_id;
	assign wr_entry.code     = exit_code;
	assign wr_entry.ip       = instr_ptr;
	assign wr_entry.detail_a = detail_a;
	assign wr_entry.detail_b = detail_b;
	assign wr_entry.reg_a    = reg_a_value;
	assign wr_entry.reg_c    = reg_c_value;
	assign wr_entry.stamp    = stamp;

	otr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	otr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.wr_entry     (wr_entry),
		.read_cursor  (read_cursor),
		.max_count    (max_count),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.has_entry    (has_entry),
		.out_cpu      (out_cpu),
		.out_code     (out_code),
		.out_ip       (out_ip),
		.out_detail_a (out_detail_a),
		.out_detail_b (out_detail_b),
		.out_reg_a    (out_reg_a),
		.out_reg_c    (out_reg_c),
		.out_stamp    (out_stamp),
		.last         (last),
		.next_cursor  (next_cursor),
		.lost_count   (lost_count)
	);

endmodule

`default_nettype wire

// File: rtl/otr_checker.sv
// port-level checks of the trace ring, bound to the top level
// depends on otr_pkg; watches overwriting_trace_ring_unit ports only
`default_nettype none

module otr_checker import otr_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        command,
	input wire        out_valid,
	input wire        out_stall,
	input wire        has_entry,
	input wire        last,
	input wire [63:0] out_ip,
	input wire [63:0] out_stamp,
	input wire [63:0] next_cursor,
	input wire [63:0] lost_count
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a drain request blocks the input while it runs
	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_DRAIN) |=> in_stall)
		else $error("input taken during a drain");

	// an empty result always ends its drain
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_entry |-> last && out_ip == 64'd0 && out_stamp == 64'd0)
		else $error("empty result not final or carries data");

	// cursor and loss only on the final result
	a_mid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> next_cursor == 64'd0 && lost_count == 64'd0)
		else $error("cursor or loss shown before the final result");

endmodule

bind overwriting_trace_ring_unit otr_checker u_otr_checker (.*);

`default_nettype wire

// File: test/tb_overwriting_trace_ring_unit.sv
// self-checking testbench of overwriting_trace_ring_unit: records and drains with random idling
// on both handshakes, checked against a shadow ring kept in the testbench
// depends on otr_pkg and the rtl of overwriting_trace_ring_unit
`default_nettype none

module tb_overwriting_trace_ring_unit;
	import otr_pkg::*;

	localparam int   RANDOM_REQUESTS = 334;
	localparam int   LONG_HOLD = 300;

	typedef struct packed {
		logic        command;
		entry_t      ev;
		logic [63:0] cursor;
		logic [6:0]  max_count;
	} trace_req_t;

	typedef struct packed {
		logic        has_entry;
		entry_t      ev;
		logic        last;
		logic [63:0] next_cursor;
		logic [63:0] lost_count;
	} drain_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_RECORD;
	logic [7:0]  cpu_id = '0;
	logic [31:0] exit_code = '0;
	logic [63:0] instr_ptr = '0;
	logic [63:0] detail_a = '0;
	logic [63:0] detail_b = '0;
	logic [63:0] reg_a_value = '0;
	logic [63:0] reg_c_value = '0;
	logic [63:0] stamp = '0;
	logic [63:0] read_cursor = '0;
	logic [6:0]  max_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        has_entry;
	logic [7:0]  out_cpu;
	logic [31:0] out_code;
	logic [63:0] out_ip;
	logic [63:0] out_detail_a;
	logic [63:0] out_detail_b;
	logic [63:0] out_reg_a;
	logic [63:0] out_reg_c;
	logic [63:0] out_stamp;
	logic        last;
	logic [63:0] next_cursor;
	logic [63:0] lost_count;

	trace_req_t    queued_requests[$];
	drain_result_t pending_drain_results[$];
	trace_req_t    held_req;
	drain_result_t seen_want;

	// shadow copy of the ring
	entry_t      shadow_ring [RING_DEPTH];
	logic [63:0] shadow_head = '0;
	logic [63:0] plan_head = '0;

	bit idle_on = 1'b1;
	bit want_long_hold = 1'b0;
	bit long_hold_done = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int fails = 0;
	int records_taken = 0;
	int drains_taken = 0;
	int drains_lossy = 0;
	int drains_capped = 0;
	int entries_checked = 0;

	overwriting_trace_ring_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.cpu_id      (cpu_id),
		.exit_code   (exit_code),
		.instr_ptr   (instr_ptr),
		.detail_a    (detail_a),
		.detail_b    (detail_b),
		.reg_a_value (reg_a_value),
		.reg_c_value (reg_c_value),
		.stamp       (stamp),
		.read_cursor (read_cursor),
		.max_count   (max_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.has_entry   (has_entry),
		.out_cpu     (out_cpu),
		.out_code    (out_code),
		.out_ip      (out_ip),
		.out_detail_a(out_detail_a),
		.out_detail_b(out_detail_b),
		.out_reg_a   (out_reg_a),
		.out_reg_c   (out_reg_c),
		.out_stamp   (out_stamp),
		.last        (last),
		.next_cursor (next_cursor),
		.lost_count  (lost_count)
	);

	always #4 clk = ~clk;

	function automatic entry_t rand_entry();
		entry_t e;
		e.cpu      = 8'($urandom);
		e.code     = $urandom;
		e.ip       = {$urandom, $urandom};
		e.detail_a = {$urandom, $urandom};
		e.detail_b = {$urandom, $urandom};
		e.reg_a    = {$urandom, $urandom};
		e.reg_c    = {$urandom, $urandom};
		e.stamp    = {$urandom, $urandom};
		return e;
	endfunction

	function automatic void push_record(entry_t e);
		trace_req_t r;
		r.command   = CMD_RECORD;
		r.ev        = e;
		r.cursor    = {$urandom, $urandom};
		r.max_count = 7'($urandom);
		queued_requests.push_back(r);
		plan_head = plan_head + 64'd1;
	endfunction

	function automatic void push_drain(logic [63:0] c, logic [6:0] m);
		trace_req_t r;
		r.command   = CMD_DRAIN;
		r.ev        = rand_entry();
		r.cursor    = c;
		r.max_count = m;
		queued_requests.push_back(r);
	endfunction

	// expected results of one accepted request
	task automatic model_trace_ring(input trace_req_t r);
		logic [63:0]   pos;
		logic [63:0]   lost;
		logic [63:0]   avail;
		logic [63:0]   n;
		logic [63:0]   idx;
		logic [6:0]    lim;
		drain_result_t res;
		if (r.command == CMD_RECORD) begin
			shadow_ring[shadow_head[RING_AW-1:0]] = r.ev;
			shadow_head = shadow_head + 64'd1;
			records_taken++;
		end else begin
			drains_taken++;
			pos = r.cursor;
			lim = r.max_count;
			lost = '0;
			res = '0;
			res.last = 1'b1;
			if (lim == '0) begin
				res.next_cursor = pos;
				pending_drain_results.push_back(res);
			end else begin
				if (lim > BURST_MAX) begin
					lim = BURST_MAX;
					drains_capped++;
				end
				if (pos == 64'd0)
					pos = (shadow_head > DEPTH64) ? shadow_head - DEPTH64 : 64'd0;
				else if (pos == ALL_ONES)
					pos = shadow_head;
				if (shadow_head > pos + DEPTH64) begin
					lost = shadow_head - DEPTH64 - pos;
					pos = shadow_head - DEPTH64;
					drains_lossy++;
				end
				if (shadow_head == 64'd0 || pos >= shadow_head) begin
					res.next_cursor = pos;
					res.lost_count = lost;
					pending_drain_results.push_back(res);
				end else begin
					avail = shadow_head - pos;
					n = (avail < 64'(lim)) ? avail : 64'(lim);
					for (int k = 0; k < int'(n); k++) begin
						idx = pos + 64'(k);
						res = '0;
						res.has_entry = 1'b1;
						res.ev = shadow_ring[idx[RING_AW-1:0]];
						if (64'(k + 1) == n) begin
							res.last = 1'b1;
							res.next_cursor = pos + n;
							res.lost_count = lost;
						end
						pending_drain_results.push_back(res);
					end
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			if (fails < 40)
				$error("%s: expected %h, got %h", name, want, got);
			fails++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_RECORD;
			cpu_id <= '0;
			exit_code <= '0;
			instr_ptr <= '0;
			detail_a <= '0;
			detail_b <= '0;
			reg_a_value <= '0;
			reg_c_value <= '0;
			stamp <= '0;
			read_cursor <= '0;
			max_count <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				model_trace_ring(held_req);
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (idle_on && queued_requests.size() != 0 &&
					$urandom_range(0, 6) == 0) begin
					gap_left <= $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					held_req = queued_requests.pop_front();
					command <= held_req.command;
					cpu_id <= held_req.ev.cpu;
					exit_code <= held_req.ev.code;
					instr_ptr <= held_req.ev.ip;
					detail_a <= held_req.ev.detail_a;
					detail_b <= held_req.ev.detail_b;
					reg_a_value <= held_req.ev.reg_a;
					reg_c_value <= held_req.ev.reg_c;
					stamp <= held_req.ev.stamp;
					read_cursor <= held_req.cursor;
					max_count <= held_req.max_count;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (want_long_hold && !long_hold_done && out_valid) begin
			long_hold_done <= 1'b1;
			stall_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drain_results.size() == 0) begin
				if (fails < 40)
					$error("unexpected result: has_entry %b last %b", has_entry, last);
				fails++;
			end else begin
				seen_want = pending_drain_results.pop_front();
				check_field("has_entry", 64'(seen_want.has_entry), 64'(has_entry));
				check_field("out_cpu", 64'(seen_want.ev.cpu), 64'(out_cpu));
				check_field("out_code", 64'(seen_want.ev.code), 64'(out_code));
				check_field("out_ip", seen_want.ev.ip, out_ip);
				check_field("out_detail_a", seen_want.ev.detail_a, out_detail_a);
				check_field("out_detail_b", seen_want.ev.detail_b, out_detail_b);
				check_field("out_reg_a", seen_want.ev.reg_a, out_reg_a);
				check_field("out_reg_c", seen_want.ev.reg_c, out_reg_c);
				check_field("out_stamp", seen_want.ev.stamp, out_stamp);
				check_field("last", 64'(seen_want.last), 64'(last));
				check_field("next_cursor", seen_want.next_cursor, next_cursor);
				check_field("lost_count", seen_want.lost_count, lost_count);
				if (seen_want.has_entry)
					entries_checked++;
			end
		end
	end

	initial begin
		#12_000_000;
		$display("FAIL overwriting_trace_ring_unit");
		$finish;
	end

	initial begin
		logic [63:0] cur;
		logic [6:0]  cnt;

		// empty ring, zero count, cursor extremes
		push_drain(64'd0, 7'd5);
		push_drain(ALL_ONES, 7'd0);
		push_drain({$urandom, $urandom}, 7'd0);
		push_record('0);
		push_record('1);
		push_record(rand_entry());
		push_record(rand_entry());
		push_record(rand_entry());
		push_drain(64'd0, 7'd127);
		push_drain(64'd2, 7'd1);
		push_drain(ALL_ONES, 7'd10);
		push_drain(plan_head + 64'd3, 7'd4);
		// wrapping cursor sum gives an overrun with a small head
		push_drain(ALL_ONES - 64'd1021, 7'd8);
		push_drain(ALL_ONES - 64'd1, 7'd3);
		push_drain(64'd1, 7'd64);
		push_drain(64'd3, 7'd65);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				push_record(rand_entry());
			end else begin
				case ($urandom_range(0, 7))
					0: cur = 64'd0;
					1: cur = ALL_ONES;
					2, 3: cur = plan_head - 64'($urandom_range(0, 80));
					4: cur = plan_head - 64'($urandom_range(900, 1300));
					5: cur = {$urandom, $urandom};
					6: cur = plan_head + 64'($urandom_range(0, 5));
					default: cur = ALL_ONES - 64'($urandom_range(0, 1100));
				endcase
				case ($urandom_range(0, 9))
					0: cnt = 7'd0;
					1: cnt = 7'($urandom_range(65, 127));
					default: cnt = 7'($urandom_range(1, 64));
				endcase
				push_drain(cur, cnt);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (queued_requests.size() > 280)
			@(posedge clk);
		want_long_hold = 1'b1;
		while (queued_requests.size() > 180)
			@(posedge clk);
		idle_on = 1'b0;
		while (queued_requests.size() > 140)
			@(posedge clk);
		idle_on = 1'b1;
		while (queued_requests.size() > 40)
			@(posedge clk);
		idle_on = 1'b0;

		while (queued_requests.size() != 0 || in_valid || pending_drain_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d records and %0d drains, %0d entries compared",
			records_taken, drains_taken, entries_checked);
		$display("drains with overrun loss %0d, count capped %0d, final head %0d",
			drains_lossy, drains_capped, shadow_head);
		if (fails == 0)
			$display("PASS overwriting_trace_ring_unit");
		else
			$display("FAIL overwriting_trace_ring_unit");
		$finish;
	end

endmodule

`default_nettype wire
